FILE: rtl/core/smvk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve kinematics package
// Shared widths, register indexes and the number of active modules.
// ----------------------------------------------------------------------------
package smvk_pkg;
	localparam int NumModules = 4;
	localparam int MaxSlots = 4;
	localparam int NumRegs = 2 * MaxSlots;
	localparam int RegIdxW = 3;
	localparam int VW = 34;   // vector component, 2^-27 units
	localparam int MW = 33;   // magnitude of a component
	localparam int SqW = 68;  // squared magnitude sum, even for the root pairs
	localparam int RootW = 34;
	localparam int DivW = 48; // dividend, magnitude << 15 plus the root
	localparam int QW = 15;   // quotient bits, result at most 16384
	typedef logic [RegIdxW-1:0] reg_idx_t;
endpackage

FILE: rtl/core/swerve_module_vector_kinematics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve module vector kinematics unit
// Four-module swerve inverse kinematics with magnitude normalization.
// ----------------------------------------------------------------------------
// One command word is accepted per cycle and one result word leaves per cycle
// once the pipeline is full, while the output is not stalled. The square root
// runs one result bit per stage, and each of the eight component dividers runs
// one quotient bit per stage. The whole pipeline advances only when its last
// stage can move, so a stall holds every word in place.
module swerve_module_vector_kinematics_unit
	import smvk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cmd_x, cmd_y, cmd_rot
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [127:0] m_tdata,  // out0_x, out0_y, ... out3_x, out3_y
	output logic        m_tuser    // scaled
);
	localparam int SqSt = RootW;
	localparam int DvSt = QW;
	localparam int NC = 2 * MaxSlots;

	logic signed [15:0] regs_q [NumRegs];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
		end else if (cfg_we && ({1'b0, cfg_idx} < 4'(NumRegs))) begin
			regs_q[cfg_idx] <= cfg_data;
		end
	end

	logic adv;
	logic m_valid_q;
	assign adv = !m_valid_q || m_tready;
	assign s_tready = adv;

	// Stage 1: products r*d.
	logic v_s1;
	logic signed [31:0] prx_s1 [MaxSlots], pry_s1 [MaxSlots];
	logic signed [15:0] x_s1, y_s1;
	// Stage 2: components.
	logic v_s2;
	logic signed [VW-1:0] c_s2 [NC];
	// Stage 3: magnitudes and squares.
	logic v_s3;
	logic [MW-1:0] a_s3 [NC];
	logic s_s3 [NC];
	// Stage 4: sum of squares.
	logic v_s4;
	logic [MW-1:0] a_s4 [NC];
	logic s_s4 [NC];
	logic [SqW-1:0] sq_s4 [MaxSlots];
	// Stage 5: max and scale flag.
	logic v_s5, sc_s5;
	logic [MW-1:0] a_s5 [NC];
	logic s_s5 [NC];
	logic [SqW-1:0] mx_s5;

	logic signed [63:0] sqa [NC];
	always_comb begin
		for (int i = 0; i < NC; i++) sqa[i] = $signed({31'd0, a_s3[i]}) * $signed({31'd0, a_s3[i]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= s_tdata[15:0];
			y_s1 <= s_tdata[31:16];
			for (int i = 0; i < MaxSlots; i++) begin
				prx_s1[i] <= $signed(s_tdata[47:32]) * regs_q[2*i+1];
				pry_s1[i] <= $signed(s_tdata[47:32]) * regs_q[2*i];
			end
			for (int i = 0; i < MaxSlots; i++) begin
				if (i < NumModules) begin
					c_s2[2*i]   <= $signed({{(VW-28){x_s1[15]}}, x_s1, 12'd0})
						- VW'(prx_s1[i]);
					c_s2[2*i+1] <= $signed({{(VW-28){y_s1[15]}}, y_s1, 12'd0})
						+ VW'(pry_s1[i]);
				end else begin
					c_s2[2*i] <= '0; c_s2[2*i+1] <= '0;
				end
			end
			for (int i = 0; i < NC; i++) begin
				s_s3[i] <= c_s2[i][VW-1];
				a_s3[i] <= c_s2[i][VW-1] ? MW'(-c_s2[i]) : MW'(c_s2[i]);
			end
			for (int i = 0; i < NC; i++) begin
				a_s4[i] <= a_s3[i]; s_s4[i] <= s_s3[i];
			end
			for (int i = 0; i < MaxSlots; i++)
				sq_s4[i] <= SqW'(unsigned'(sqa[2*i])) + SqW'(unsigned'(sqa[2*i+1]));
			for (int i = 0; i < NC; i++) begin
				a_s5[i] <= a_s4[i]; s_s5[i] <= s_s4[i];
			end
			begin
				logic [SqW-1:0] m;
				m = '0;
				for (int i = 0; i < MaxSlots; i++) if (sq_s4[i] > m) m = sq_s4[i];
				mx_s5 <= m;
				sc_s5 <= m > (SqW'(1) << 54);
			end
		end
	end

	// Square root: one result bit per stage, restoring method.
	logic rv [SqSt+1];
	logic rsc [SqSt+1];
	logic [SqW+1:0] rrem [SqSt+1];
	logic [SqW-1:0] rn [SqSt+1];
	logic [RootW-1:0] rroot [SqSt+1];
	logic [MW-1:0] ra [SqSt+1][NC];
	logic rs [SqSt+1][NC];
	always_comb begin
		rv[0] = v_s5; rsc[0] = sc_s5; rrem[0] = '0; rn[0] = mx_s5; rroot[0] = '0;
		for (int i = 0; i < NC; i++) begin ra[0][i] = a_s5[i]; rs[0][i] = s_s5[i]; end
	end
	for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
		logic [SqW+1:0] rem_sh, trial;
		logic [RootW-1:0] cur_root;
		always_comb begin
			cur_root = rroot[k];
			rem_sh = {rrem[k][SqW-1:0], rn[k][SqW-1 -: 2]};
			trial = (SqW+2)'({cur_root, 2'b01});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[k+1] <= 1'b0;
			else if (adv) rv[k+1] <= rv[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rsc[k+1] <= rsc[k];
				rn[k+1] <= {rn[k][SqW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rrem[k+1] <= rem_sh - trial;
					rroot[k+1] <= {cur_root[RootW-2:0], 1'b1};
				end else begin
					rrem[k+1] <= rem_sh;
					rroot[k+1] <= {cur_root[RootW-2:0], 1'b0};
				end
				for (int i = 0; i < NC; i++) begin
					ra[k+1][i] <= ra[k][i]; rs[k+1][i] <= rs[k][i];
				end
			end
		end
	end

	// Dividers: (2n + m) / (2m), one quotient bit per stage.
	logic dv [DvSt+1];
	logic dsc [DvSt+1];
	logic [RootW:0] dd [DvSt+1];
	logic [DivW+1:0] dr [DvSt+1][NC];
	logic [QW-1:0] dq [DvSt+1][NC];
	logic [MW-1:0] da [DvSt+1][NC];
	logic ds [DvSt+1][NC];
	always_comb begin
		dv[0] = rv[SqSt]; dsc[0] = rsc[SqSt];
		dd[0] = {rroot[SqSt], 1'b0};
		for (int i = 0; i < NC; i++) begin
			dr[0][i] = {ra[SqSt][i], 15'd0} + (DivW+2)'(rroot[SqSt]);
			dq[0][i] = '0; da[0][i] = ra[SqSt][i]; ds[0][i] = rs[SqSt][i];
		end
	end
	for (genvar k = 0; k < DvSt; k++) begin : g_div
		localparam int Sh = QW - 1 - k;
		logic [DivW+RootW+1:0] tr [NC];
		always_comb begin
			for (int i = 0; i < NC; i++)
				tr[i] = (DivW+RootW+2)'(dd[k]) << Sh;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else if (adv) dv[k+1] <= dv[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dsc[k+1] <= dsc[k]; dd[k+1] <= dd[k];
				for (int i = 0; i < NC; i++) begin
					da[k+1][i] <= da[k][i]; ds[k+1][i] <= ds[k][i];
					if (dsc[k] && ((DivW+RootW+2)'(dr[k][i]) >= tr[i])) begin
						dr[k+1][i] <= dr[k][i] - (DivW+2)'(tr[i]);
						dq[k+1][i] <= dq[k][i] | (QW'(1) << Sh);
					end else begin
						dr[k+1][i] <= dr[k][i];
						dq[k+1][i] <= dq[k][i];
					end
				end
			end
		end
	end

	// Output: pick path, sign, clamp.
	logic [127:0] od_q;
	logic osc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (adv) m_valid_q <= dv[DvSt];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			osc_q <= dsc[DvSt];
			for (int i = 0; i < NC; i++) begin
				logic [MW-1:0] mg;
				logic [MW-1:0] lim;
				mg = dsc[DvSt] ? MW'(dq[DvSt][i]) : MW'((da[DvSt][i] + MW'(4096)) >> 13);
				lim = (mg > MW'(16384)) ? MW'(16384) : mg;
				od_q[16*i +: 16] <= ds[DvSt][i] ? 16'(-lim[15:0]) : lim[15:0];
			end
		end
	end
	assign m_tvalid = m_valid_q;
	assign m_tdata = od_q;
	assign m_tuser = osc_q;
endmodule

FILE: dv/swerve_module_vector_kinematics_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve module vector kinematics unit testbench
// Drives drive commands through the stream port under several module offset
// settings and random stalls on both sides, and compares every result word
// with an in-bench prediction of the four module power vectors.
// ----------------------------------------------------------------------------
module swerve_module_vector_kinematics_unit_test;
	import smvk_pkg::*;

	localparam int Latency = 4 + 34 + 15 + 2;
	localparam int CycleLimit = 400000;
	localparam logic [2:0] RegMod0Dx = 3'd0;
	localparam logic [2:0] RegMod0Dy = 3'd1;
	localparam logic [2:0] RegMod1Dx = 3'd2;
	localparam logic [2:0] RegMod1Dy = 3'd3;
	localparam logic [2:0] RegMod2Dx = 3'd4;
	localparam logic [2:0] RegMod2Dy = 3'd5;
	localparam logic [2:0] RegMod3Dx = 3'd6;
	localparam logic [2:0] RegMod3Dy = 3'd7;

	typedef struct packed {
		logic          scaled;
		logic [127:0]  vecs;
	} drive_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic m_tuser;

	logic signed [15:0] offsets [NumRegs];
	drive_out_t expected_q [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_recv = 1'b0;
	int hold_cycles = 0;
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int scaled_seen = 0;
	int cycle_count = 0;

	swerve_module_vector_kinematics_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] clamp_q14(longint v);
		if (v > 16384)
			v = 16384;
		if (v < -16384)
			v = -16384;
		return v[15:0];
	endfunction

	function automatic drive_out_t predict_vectors(logic [47:0] cmd);
		longint vc [2*MaxSlots];
		longint unsigned mags [2*MaxSlots];
		longint x, y, r;
		longint unsigned sq, maxsq, root, q;
		drive_out_t res;
		x = longint'(signed'(cmd[15:0])) * 4096;
		y = longint'(signed'(cmd[31:16])) * 4096;
		r = longint'(signed'(cmd[47:32]));
		maxsq = 0;
		res = '0;
		for (int i = 0; i < 2*MaxSlots; i++)
			vc[i] = 0;
		for (int i = 0; i < NumModules; i++) begin
			vc[2*i] = x - r * longint'(offsets[2*i+1]);
			vc[2*i+1] = y + r * longint'(offsets[2*i]);
			mags[2*i] = (vc[2*i] < 0) ? -vc[2*i] : vc[2*i];
			mags[2*i+1] = (vc[2*i+1] < 0) ? -vc[2*i+1] : vc[2*i+1];
			sq = mags[2*i] * mags[2*i] + mags[2*i+1] * mags[2*i+1];
			if (sq > maxsq)
				maxsq = sq;
		end
		res.scaled = maxsq > (64'd1 << 54);
		root = int_sqrt(maxsq);
		for (int i = 0; i < 2*NumModules; i++) begin
			if (res.scaled)
				q = (2 * (mags[i] << 14) + root) / (2 * root);
			else
				q = (mags[i] + 4096) >> 13;
			vc[i] = (vc[i] < 0) ? -longint'(q) : longint'(q);
		end
		for (int i = 0; i < 2*MaxSlots; i++)
			res.vecs[16*i +: 16] = clamp_q14(vc[i]);
		return res;
	endfunction

	task automatic write_offset(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		offsets[idx] = val;
		@(posedge clk);
	endtask

	task automatic send_command(logic [15:0] cx, logic [15:0] cy, logic [15:0] cr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cr, cy, cx};
		expected_q.push_back(predict_vectors({cr, cy, cx}));
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
	endtask

	task automatic drain_pipeline;
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	function automatic logic [15:0] random_value;
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(signed'($urandom_range(2000)) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_offsets(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
			logic [15:0] v3, logic [15:0] v4, logic [15:0] v5,
			logic [15:0] v6, logic [15:0] v7);
		write_offset(RegMod0Dx, v0);
		write_offset(RegMod0Dy, v1);
		write_offset(RegMod1Dx, v2);
		write_offset(RegMod1Dy, v3);
		write_offset(RegMod2Dx, v4);
		write_offset(RegMod2Dy, v5);
		write_offset(RegMod3Dx, v6);
		write_offset(RegMod3Dy, v7);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed;
		send_command(16'h0000, 16'h0000, 16'h0000);
		send_command(16'h7fff, 16'h0000, 16'h0000);
		send_command(16'h8000, 16'h8000, 16'h0000);
		send_command(16'h7fff, 16'h7fff, 16'h7fff);
		send_command(16'h0001, 16'hffff, 16'h0000);
		send_command(16'h0003, 16'hfffd, 16'h0000);
		drain_pipeline();
		load_offsets(16'h1000, 16'h1000, 16'hf000, 16'h1000,
			16'hf000, 16'hf000, 16'h1000, 16'hf000);
		send_command(16'h0000, 16'h0000, 16'h7fff);
		send_command(16'h0000, 16'h0000, 16'h8000);
		send_command(16'h4000, 16'h0000, 16'h4000);
		send_command(16'h2d41, 16'h2d41, 16'h0000);
		send_command(16'h8000, 16'h7fff, 16'h8000);
		drain_pipeline();
		load_offsets(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
		send_command(16'h7fff, 16'h8000, 16'h7fff);
		send_command(16'h8000, 16'h8000, 16'h8000);
		send_command(16'h0000, 16'h0000, 16'h0001);
		send_command(16'hffff, 16'hffff, 16'hffff);
		drain_pipeline();
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++)
			send_command(random_value(), random_value(), random_value());
	endtask

	task automatic test_random_offsets;
		for (int ph = 0; ph < 3; ph++) begin
			load_offsets(random_value(), random_value(), random_value(), random_value(),
				random_value(), random_value(), random_value(), random_value());
			send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 7 : 0;
			test_random(170);
			drain_pipeline();
		end
	endtask

	task automatic test_backpressure;
		load_offsets(16'h0800, 16'hf800, 16'h0800, 16'h0800,
			16'hf800, 16'h0800, 16'hf800, 16'hf800);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 150;
		hold_recv = 1'b1;
		test_random(120);
		drain_pipeline();
	endtask

	always @(posedge clk) begin
		if (hold_recv) begin
			m_tready <= 1'b0;
			if (hold_cycles == 0)
				hold_recv <= 1'b0;
			else
				hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		drive_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word %h scaled %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = expected_q.pop_front();
				words_checked++;
				if (m_tuser)
					scaled_seen++;
				for (int i = 0; i < 2*MaxSlots; i++)
					if (m_tdata[16*i +: 16] !== want.vecs[16*i +: 16]) begin
						$display("%0t: component %0d expected %0d actual %0d", $time, i,
							signed'(want.vecs[16*i +: 16]), signed'(m_tdata[16*i +: 16]));
						errors++;
					end
				if (m_tuser !== want.scaled) begin
					$display("%0t: scaled expected %b actual %b", $time, want.scaled,
						m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NumRegs; i++)
			offsets[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_offsets();
		test_backpressure();
		$display("Sent %0d command words, checked %0d results, %0d of them scaled,",
			words_sent, words_checked, scaled_seen);
		$display("over directed offsets, three random offset sets and a long output stall.");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d words outstanding", errors, expected_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
